// ===== sv/bftl_pkg.sv =====
// ============================================================================
// bftl_pkg
// Shared types, codes and arithmetic helpers for the bitmap font text layout.
// ============================================================================
package bftl_pkg;

    localparam int POS_W          = 20;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 20;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic signed [POS_W-1:0] POS_MAX = 20'sh7FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 20'sh80000;

    localparam logic [CFG_IDX_W-1:0] REG_START_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_MIN_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_MIN_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_MAX_X = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_MAX_Y = 3'd7;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_GLYPH   = 2'd1,
        CMD_NEWLINE = 2'd2
    } cmd_t;

    typedef struct packed {
        logic signed [19:0] start_x;
        logic [18:0]        max_width;
        logic [7:0]         line_height;
        logic [11:0]        scale;
        logic [12:0]        amin_x;
        logic [12:0]        amin_y;
        logic [12:0]        amax_x;
        logic [12:0]        amax_y;
    } cfg_t;

    typedef struct packed {
        cmd_t               kind;
        logic signed [19:0] origin_y;
        logic [15:0]        lh;
        logic [15:0]        adv;
        logic signed [16:0] xo_s;
        logic signed [16:0] yo_s;
        logic [15:0]        qw;
        logic [15:0]        qh;
        logic [12:0]        tmin_x;
        logic [12:0]        tmin_y;
        logic [12:0]        tmax_x;
        logic [12:0]        tmax_y;
    } work_t;

    function automatic logic signed [19:0] sat_pos(input logic signed [20:0] v);
        logic signed [19:0] r;
        if (v[20] != v[19])
        begin
            r = v[20] ? POS_MIN : POS_MAX;
        end
        else
        begin
            r = v[19:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] scale_u8(input logic [7:0] a, input logic [11:0] s);
        logic [19:0] p;
        p = {12'd0, a} * {8'd0, s};
        return p[19:4];
    endfunction

    // Floor rounding falls out of dropping the low bits of the signed product.
    function automatic logic signed [16:0] scale_s8(input logic [7:0] a,
                                                   input logic [11:0] s);
        logic signed [20:0] p;
        p = $signed({{13{a[7]}}, a}) * $signed({9'd0, s});
        return p[20:4];
    endfunction

    function automatic logic [12:0] clamp13(input logic [13:0] v,
                                            input logic [12:0] lo,
                                            input logic [12:0] hi);
        logic [13:0] t;
        t = (v < {1'b0, lo}) ? {1'b0, lo} : v;
        if (t > {1'b0, hi})
        begin
            t = {1'b0, hi};
        end
        return t[12:0];
    endfunction

endpackage

// ===== sv/bftl_if.sv =====
// ============================================================================
// bftl_in_if / bftl_out_if
// Valid/ready channels for glyph commands and for laid-out quads.
// ============================================================================
interface bftl_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [19:0] origin_y;
    logic [11:0]        glyph_x;
    logic [11:0]        glyph_y;
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
    logic signed [7:0]  glyph_xoff;
    logic signed [7:0]  glyph_yoff;
    logic [7:0]         glyph_advance;

    modport source (
        output valid, cmd, origin_y, glyph_x, glyph_y, glyph_width, glyph_height,
               glyph_xoff, glyph_yoff, glyph_advance,
        input  ready
    );
    modport sink (
        input  valid, cmd, origin_y, glyph_x, glyph_y, glyph_width, glyph_height,
               glyph_xoff, glyph_yoff, glyph_advance,
        output ready
    );
endinterface

interface bftl_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] quad_x;
    logic signed [19:0] quad_y;
    logic [15:0]        quad_w;
    logic [15:0]        quad_h;
    logic [12:0]        tex_min_x;
    logic [12:0]        tex_min_y;
    logic [12:0]        tex_max_x;
    logic [12:0]        tex_max_y;

    modport source (
        output valid, quad_x, quad_y, quad_w, quad_h,
               tex_min_x, tex_min_y, tex_max_x, tex_max_y,
        input  ready
    );
    modport sink (
        input  valid, quad_x, quad_y, quad_w, quad_h,
               tex_min_x, tex_min_y, tex_max_x, tex_max_y,
        output ready
    );
endinterface

// ===== sv/bftl_front.sv =====
// ============================================================================
// bftl_front
// Accepts commands, drops unused codes, and computes every pen-independent
// term of an item: scaled metrics and the clamped atlas rectangle.
// ============================================================================
module bftl_front
    import bftl_pkg::*;
(
    input  cfg_t        cfg,
    bftl_in_if.sink     glyphs,
    output logic        push_valid,
    output work_t       push_data,
    input  logic        push_ready
);

    logic        legal;
    logic [13:0] base_x;
    logic [13:0] base_y;

    assign glyphs.ready = push_ready;
    assign push_valid   = glyphs.valid && legal;

    assign base_x = {1'b0, cfg.amin_x} + {2'd0, glyphs.glyph_x};
    assign base_y = {1'b0, cfg.amin_y} + {2'd0, glyphs.glyph_y};

    always_comb
    begin
        legal          = 1'b1;
        push_data.kind = CMD_GLYPH;
        case (glyphs.cmd)
            CMD_START:   push_data.kind = CMD_START;
            CMD_GLYPH:   push_data.kind = CMD_GLYPH;
            CMD_NEWLINE: push_data.kind = CMD_NEWLINE;
            default:     legal = 1'b0;
        endcase
        push_data.origin_y = glyphs.origin_y;
        push_data.lh       = scale_u8(cfg.line_height, cfg.scale);
        push_data.adv      = scale_u8(glyphs.glyph_advance, cfg.scale);
        push_data.xo_s     = scale_s8(glyphs.glyph_xoff, cfg.scale);
        push_data.yo_s     = scale_s8(glyphs.glyph_yoff, cfg.scale);
        push_data.qw       = scale_u8(glyphs.glyph_width, cfg.scale);
        push_data.qh       = scale_u8(glyphs.glyph_height, cfg.scale);
        push_data.tmin_x   = clamp13(base_x, cfg.amin_x, cfg.amax_x);
        push_data.tmin_y   = clamp13(base_y, cfg.amin_y, cfg.amax_y);
        push_data.tmax_x   = clamp13(base_x + {6'd0, glyphs.glyph_width},
                                     cfg.amin_x, cfg.amax_x);
        push_data.tmax_y   = clamp13(base_y + {6'd0, glyphs.glyph_height},
                                     cfg.amin_y, cfg.amax_y);
    end

endmodule

// ===== sv/bftl_queue.sv =====
// ============================================================================
// bftl_queue
// Short first-in first-out queue of work items between front and back.
// ============================================================================
module bftl_queue
    import bftl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    input  work_t push_data,
    output logic  push_ready,
    output logic  pop_valid,
    output work_t pop_data,
    input  logic  pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

    work_t            entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULLC);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/bftl_back.sv =====
// ============================================================================
// bftl_back
// Holds the pen, applies wrap, start and newline, and registers each quad.
// ============================================================================
module bftl_back
    import bftl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        pop_valid,
    input  work_t       pop_data,
    output logic        pop_ready,
    bftl_out_if.source  quads
);

    logic signed [19:0] pen_x_reg;
    logic signed [19:0] pen_y_reg;
    logic               out_valid_reg;

    logic signed [19:0] quad_x_reg;
    logic signed [19:0] quad_y_reg;
    logic [15:0]        quad_w_reg;
    logic [15:0]        quad_h_reg;
    logic [12:0]        tex_min_x_reg;
    logic [12:0]        tex_min_y_reg;
    logic [12:0]        tex_max_x_reg;
    logic [12:0]        tex_max_y_reg;

    logic [20:0]        diff;
    logic [21:0]        room;
    logic               wrap;
    logic signed [19:0] lh_y;
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [19:0] qx;
    logic signed [19:0] qy;
    logic signed [19:0] pen_x_next;
    logic               out_free;
    logic               do_pop;

    assign out_free  = !out_valid_reg || quads.ready;
    assign pop_ready = (pop_data.kind != CMD_GLYPH) || out_free;
    assign do_pop    = pop_valid && pop_ready;

    assign diff = {pen_x_reg[19], pen_x_reg} - {cfg.start_x[19], cfg.start_x};
    assign room = {diff[20], diff} + {6'd0, pop_data.adv};
    assign wrap = $signed(room) > $signed({3'd0, cfg.max_width});
    assign lh_y = sat_pos({pen_y_reg[19], pen_y_reg} + {5'd0, pop_data.lh});
    assign px   = wrap ? cfg.start_x : pen_x_reg;
    assign py   = wrap ? lh_y : pen_y_reg;
    assign qx   = sat_pos({px[19], px} + {{4{pop_data.xo_s[16]}}, pop_data.xo_s});
    assign qy   = sat_pos({py[19], py} + {{4{pop_data.yo_s[16]}}, pop_data.yo_s});
    assign pen_x_next = sat_pos({px[19], px} + {5'd0, pop_data.adv});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_pop && (pop_data.kind == CMD_GLYPH))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (quads.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (do_pop)
            begin
                case (pop_data.kind)
                    CMD_START:
                    begin
                        pen_x_reg <= cfg.start_x;
                        pen_y_reg <= pop_data.origin_y;
                    end
                    CMD_NEWLINE:
                    begin
                        pen_x_reg <= cfg.start_x;
                        pen_y_reg <= lh_y;
                    end
                    CMD_GLYPH:
                    begin
                        pen_x_reg <= pen_x_next;
                        pen_y_reg <= py;
                    end
                    default:
                    begin
                        pen_x_reg <= pen_x_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && (pop_data.kind == CMD_GLYPH))
        begin
            quad_x_reg    <= qx;
            quad_y_reg    <= qy;
            quad_w_reg    <= pop_data.qw;
            quad_h_reg    <= pop_data.qh;
            tex_min_x_reg <= pop_data.tmin_x;
            tex_min_y_reg <= pop_data.tmin_y;
            tex_max_x_reg <= pop_data.tmax_x;
            tex_max_y_reg <= pop_data.tmax_y;
        end
    end

    assign quads.valid     = out_valid_reg;
    assign quads.quad_x    = quad_x_reg;
    assign quads.quad_y    = quad_y_reg;
    assign quads.quad_w    = quad_w_reg;
    assign quads.quad_h    = quad_h_reg;
    assign quads.tex_min_x = tex_min_x_reg;
    assign quads.tex_min_y = tex_min_y_reg;
    assign quads.tex_max_x = tex_max_x_reg;
    assign quads.tex_max_y = tex_max_y_reg;

endmodule

// ===== sv/bitmap_font_text_layout_top.sv =====
// ============================================================================
// bitmap_font_text_layout_top
// Lays out bitmap-font glyphs along a pen with character wrapping.
// ============================================================================
//  Channel   Direction  Handshake        Payload
//  glyphs    in         valid / ready    cmd, origin_y, glyph metrics
//  quads     out        valid / ready    quad position and size, texel rect
//  cfg       in         cfg_we           cfg_index, cfg_data
//
//  One item is accepted per cycle while the queue has room; a glyph's item
//  is held in the queue and then registered as a quad in the back stage.
//  The rate is set by the pen update in the back stage.
//  Reset clears the pen, the queue and the registers to their defaults.
//  A stalled output fills the queue of QUEUE_DEPTH items before input stalls.
// ============================================================================
module bitmap_font_text_layout_top
    import bftl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bftl_in_if.sink               glyphs,
    bftl_out_if.source            quads
);

    cfg_t  cfg_reg;
    logic  push_valid;
    work_t push_data;
    logic  push_ready;
    logic  pop_valid;
    work_t pop_data;
    logic  pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_x     <= '0;
            cfg_reg.max_width   <= '0;
            cfg_reg.line_height <= '0;
            cfg_reg.scale       <= 12'd256;
            cfg_reg.amin_x      <= '0;
            cfg_reg.amin_y      <= '0;
            cfg_reg.amax_x      <= 13'd8191;
            cfg_reg.amax_y      <= 13'd8191;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_X:     cfg_reg.start_x     <= cfg_data;
                REG_MAX_WIDTH:   cfg_reg.max_width   <= cfg_data[18:0];
                REG_LINE_HEIGHT: cfg_reg.line_height <= cfg_data[7:0];
                REG_SCALE:       cfg_reg.scale       <= cfg_data[11:0];
                REG_ATLAS_MIN_X: cfg_reg.amin_x      <= cfg_data[12:0];
                REG_ATLAS_MIN_Y: cfg_reg.amin_y      <= cfg_data[12:0];
                REG_ATLAS_MAX_X: cfg_reg.amax_x      <= cfg_data[12:0];
                REG_ATLAS_MAX_Y: cfg_reg.amax_y      <= cfg_data[12:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    bftl_front u_front (
        .cfg        (cfg_reg),
        .glyphs     (glyphs),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    bftl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    bftl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .quads     (quads)
    );

endmodule
